// ----- src/cnlv_pkg.sv -----
// Shared constants and types for the card number check block.
package cnlv_pkg;
   localparam int CardWidth  = 54;
   localparam int CountWidth = 5;
   localparam int SumWidth   = 8;
   localparam int Cells      = 17;

   localparam logic [1:0] VerdictInvalid = 2'd0;
   localparam logic [1:0] VerdictLead3x  = 2'd1;
   localparam logic [1:0] VerdictLead5x  = 2'd2;
   localparam logic [1:0] VerdictLead4   = 2'd3;

   typedef struct packed {
      logic                  live;
      logic [CardWidth-1:0]  rest;
      logic [SumWidth-1:0]   sum;
      logic [CountWidth-1:0] count;
      logic [3:0]            lead_hi;
      logic [3:0]            lead_lo;
   } stage_type;

   function automatic logic [3:0] luhn_add(input logic [3:0] d, input logic dbl);
      logic [4:0] t;
      begin
         t = {d, 1'b0};
         if (!dbl) luhn_add = d;
         else if (t >= 5'd10) luhn_add = 4'(t - 5'd9);
         else luhn_add = t[3:0];
      end
   endfunction
endpackage

// ----- src/cnlv_cell.sv -----
// One digit cell: take the decimal digit at a fixed place and fold it into the running sum.
module cnlv_cell #(
   parameter int Place = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cnlv_pkg::stage_type stage_in,
   output cnlv_pkg::stage_type stage_out
);
   function automatic logic [63:0] pow10(input int p);
      logic [63:0] r;
      r = 64'd1;
      for (int i = 0; i < p; i++) r = r * 64'd10;
      return r;
   endfunction

   localparam int          W       = cnlv_pkg::CardWidth;
   localparam logic [63:0] Scale   = pow10(Place);
   localparam logic        Doubled = (Place % 2) == 1;

   logic [63:0]                wide;
   logic [63:0]                step;
   logic [63:0]                take;
   logic [3:0]                 digit;
   cnlv_pkg::stage_type        stage_ff;
   cnlv_pkg::stage_type        stage_in_n;

   always_comb begin
      wide  = {{(64-W){1'b0}}, stage_in.rest};
      step  = '0;
      take  = '0;
      digit = '0;
      for (int k = 1; k < 10; k++) begin
         step = step + Scale;
         if (wide >= step) begin
            take  = step;
            digit = 4'(k);
         end
      end
      stage_in_n      = stage_in;
      stage_in_n.rest = stage_in.rest - take[W-1:0];
      stage_in_n.sum  = stage_in.sum + {4'd0, cnlv_pkg::luhn_add(digit, Doubled)};
      if (stage_in.count == '0) begin
         if (digit != '0) begin
            stage_in_n.count   = 5'(Place + 1);
            stage_in_n.lead_hi = digit;
         end
      end else if (stage_in.count == 5'(Place + 2)) begin
         stage_in_n.lead_lo = digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) stage_ff.live <= 1'b0;
      else stage_ff.live <= stage_in.live;
      stage_ff.rest    <= stage_in_n.rest;
      stage_ff.sum     <= stage_in_n.sum;
      stage_ff.count   <= stage_in_n.count;
      stage_ff.lead_hi <= stage_in_n.lead_hi;
      stage_ff.lead_lo <= stage_in_n.lead_lo;
   end

   assign stage_out = stage_ff;
endmodule

// ----- src/card_number_luhn_validator.sv -----
// Top level: Luhn check and prefix class of one binary card number.
// The request passes through 17 digit cells, one per decimal place, then the
// classify logic into the output register.
// The chain holds one request at a time: a new request is stalled until the
// result has been taken, so rsp_stall also holds off the next request.
// Reset (synchronous, active high) empties the chain and the output register.
module card_number_luhn_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [53:0] req_card_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_checksum_ok,
   output logic [4:0]  rsp_digit_count
);
   localparam int N = cnlv_pkg::Cells;

   cnlv_pkg::stage_type chain [0:N];
   logic                busy_ff, busy_in;
   logic                res_valid_ff;
   logic [1:0]          res_verdict_ff;
   logic                res_ok_ff;
   logic [4:0]          res_count_ff;
   logic                ok;
   logic [1:0]          verdict;
   logic [7:0]          lead;
   logic [4:0]          cnt;
   logic                done;

   assign req_stall = busy_ff || reset;

   always_comb begin
      chain[0]         = '0;
      chain[0].live    = req_valid && !req_stall;
      chain[0].rest    = req_card_number;
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         cnlv_cell #(.Place(N - 1 - g)) u_cell (.clock(clock), .reset(reset),
                           .stage_in(chain[g]), .stage_out(chain[g+1]));
      end
   endgenerate

   always_comb begin
      cnt  = chain[N].count;
      lead = ({4'd0, chain[N].lead_hi} * 8'd10) + {4'd0, chain[N].lead_lo};
      ok   = chain[N].sum inside {8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70,
                                  8'd80, 8'd90, 8'd100, 8'd110, 8'd120, 8'd130, 8'd140,
                                  8'd150};
      verdict = cnlv_pkg::VerdictInvalid;
      if (ok) begin
         if (cnt == 5'd15 && (lead == 8'd34 || lead == 8'd37))
            verdict = cnlv_pkg::VerdictLead3x;
         else if (cnt == 5'd16 && lead >= 8'd51 && lead <= 8'd55)
            verdict = cnlv_pkg::VerdictLead5x;
         else if ((cnt == 5'd16 || cnt == 5'd13) && chain[N].lead_hi == 4'd4)
            verdict = cnlv_pkg::VerdictLead4;
      end
      done    = rsp_valid && !rsp_stall;
      busy_in = busy_ff;
      if (req_valid && !req_stall) busy_in = 1'b1;
      else if (done) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (chain[N].live) res_valid_ff <= 1'b1;
         else if (done) res_valid_ff <= 1'b0;
      end
      if (chain[N].live) begin
         res_verdict_ff <= verdict;
         res_ok_ff      <= ok;
         res_count_ff   <= cnt;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_verdict     = res_verdict_ff;
   assign rsp_checksum_ok = res_ok_ff;
   assign rsp_digit_count = res_count_ff;
endmodule
